// ===== rtl/cda_pkg.sv =====
package cda_pkg;

    localparam int YEAR_BITS_DEF   = 16;
    localparam int AMOUNT_BITS_DEF = 16;

    localparam int YEAR_W   = 16;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int AMOUNT_W = 16;

    localparam int DIV_W = 33;
    localparam int SUM_W = DIV_W + 1;
    localparam int MOD_W = 9;

    localparam int MUL_W       = 32;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int RECIP_SHIFT = 33;
    localparam int QUO_W       = PROD_W - RECIP_SHIFT;
    localparam int MONTH_SHIFT = 2;
    localparam int CYCLE_SHIFT = 4;

    // Quotients come from a multiply by the rounded-up reciprocal of 3 or 25,
    // taking the product bits above RECIP_SHIFT.
    localparam logic [MUL_W-1:0] RECIP_MONTHS = 32'hAAAA_AAAB;
    localparam logic [MUL_W-1:0] RECIP_CYCLE  = 32'd343597384;

    localparam int YEAR_CYCLE      = 400;
    localparam int CYCLE_ODD       = YEAR_CYCLE >> CYCLE_SHIFT;
    localparam int CENTURY         = 100;
    localparam int MONTHS_PER_YEAR = 12;
    localparam int FEB_LEAP_DAYS   = 29;
    localparam int LAST_DAY        = 31;

    localparam int RESET_YEAR  = 2012;
    localparam int RESET_MONTH = 7;
    localparam int RESET_DAY   = 12;

    typedef enum logic [1:0] {
        OP_SET        = 2'd0,
        OP_ADD_DAYS   = 2'd1,
        OP_ADD_MONTHS = 2'd2,
        OP_ADD_YEARS  = 2'd3
    } op_t;

    typedef logic [DAY_W-1:0] month_days_t [MONTHS_PER_YEAR];

    localparam month_days_t MONTH_DAYS = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic latch;
        logic set_apply;
        logic day_step;
        logic div_load;
        logic div_mul;
        logic month_apply;
        logic year_apply;
        logic mod_mul;
        logic mod_apply;
        logic clamp;
    } cda_cmd_t;

    typedef struct packed {
        op_t  op;
        logic day_fin;
    } cda_status_t;

    function automatic logic [DAY_W-1:0] month_length(logic [MONTH_W-1:0] month,
                                                      logic leap);
        logic [DAY_W-1:0] len;
        if (month < 4'd1 || month > 4'd12) begin
            len = MONTH_DAYS[0];
        end else begin
            len = MONTH_DAYS[month - 4'd1];
        end
        if (month == 4'd2 && leap) begin
            len = DAY_W'(FEB_LEAP_DAYS);
        end
        return len;
    endfunction

endpackage

// ===== rtl/cda_ctrl.sv =====
module cda_ctrl
    import cda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  cda_status_t status,
    output cda_cmd_t    cmd,
    output logic        busy,
    output logic        done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SET,
        S_DAYS,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_MONTH,
        S_YEAR,
        S_MOD_LOAD,
        S_MOD_RUN,
        S_CLAMP,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (status.op)
                    OP_SET:        state_next = S_SET;
                    OP_ADD_DAYS:   state_next = S_DAYS;
                    OP_ADD_MONTHS: state_next = S_DIV_LOAD;
                    OP_ADD_YEARS:  state_next = S_YEAR;
                    default:       state_next = S_SET;
                endcase
            end
            S_SET:      state_next = S_MOD_LOAD;
            S_DAYS:
            begin
                if (status.day_fin) begin
                    state_next = S_MOD_LOAD;
                end
            end
            S_DIV_LOAD: state_next = S_DIV_RUN;
            S_DIV_RUN:  state_next = S_MONTH;
            S_MONTH:    state_next = S_MOD_LOAD;
            S_YEAR:     state_next = S_MOD_LOAD;
            S_MOD_LOAD: state_next = S_MOD_RUN;
            S_MOD_RUN:  state_next = S_CLAMP;
            S_CLAMP:    state_next = S_DONE;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= (state_next == S_DONE);
        end
    end

    always_comb
    begin
        cmd             = '0;
        cmd.latch       = (state_reg == S_IDLE);
        cmd.set_apply   = (state_reg == S_SET);
        cmd.day_step    = (state_reg == S_DAYS);
        cmd.div_load    = (state_reg == S_DIV_LOAD);
        cmd.div_mul     = (state_reg == S_DIV_RUN);
        cmd.month_apply = (state_reg == S_MONTH);
        cmd.year_apply  = (state_reg == S_YEAR);
        cmd.mod_mul     = (state_reg == S_MOD_LOAD);
        cmd.mod_apply   = (state_reg == S_MOD_RUN);
        cmd.clamp       = (state_reg == S_CLAMP);
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ===== rtl/cda_datapath.sv =====
module cda_datapath
    import cda_pkg::*;
#(
    parameter int YEAR_BITS   = YEAR_BITS_DEF,
    parameter int AMOUNT_BITS = AMOUNT_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cda_cmd_t            cmd,
    output cda_status_t         status,
    input  logic [1:0]          operation,
    input  logic [YEAR_W-1:0]   year_value,
    input  logic [MONTH_W-1:0]  month_value,
    input  logic [DAY_W-1:0]    day_value,
    input  logic [AMOUNT_W-1:0] amount,
    output logic [YEAR_W-1:0]   year_out,
    output logic [MONTH_W-1:0]  month_out,
    output logic [DAY_W-1:0]    day_out,
    output logic                year_overflow
);

    localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;

    op_t                    op_reg;
    logic [YEAR_W-1:0]      yv_reg;
    logic [MONTH_W-1:0]     mv_reg;
    logic [DAY_W-1:0]       dv_reg;
    logic [AMOUNT_BITS-1:0] amt_reg;
    logic [YEAR_BITS-1:0]   year_reg;
    logic [MONTH_W-1:0]     month_reg;
    logic [DAY_W-1:0]       day_reg;
    logic                   ovf_reg;
    logic [MOD_W-1:0]       ymod_reg;
    logic [DIV_W-1:0]       div_reg;
    logic [QUO_W-1:0]       quo_reg;

    logic [31:0]            amount_wide;
    logic [31:0]            yv_wide;
    logic [31:0]            year_wide;
    logic                   leap;
    logic [DAY_W-1:0]       len;
    logic [AMOUNT_BITS:0]   day_sum;
    logic                   fits;
    logic                   at_end;
    logic [DAY_W-1:0]       step_days;
    logic [MOD_W-1:0]       ymod_inc;
    logic [MUL_W-1:0]       year_hi;
    logic [MUL_W-1:0]       mul_a;
    logic [MUL_W-1:0]       mul_b;
    logic [PROD_W-1:0]      mul_p;
    logic [DIV_W-1:0]       month_rem;
    logic [MUL_W-1:0]       cyc_rem;
    logic [SUM_W-1:0]       year_sum_month;
    logic [SUM_W-1:0]       year_sum_year;

    assign amount_wide = 32'(amount);
    assign yv_wide     = 32'(yv_reg);
    assign year_wide   = 32'(year_reg);

    assign leap = (year_reg[1:0] == 2'b00)
               && (ymod_reg != MOD_W'(CENTURY))
               && (ymod_reg != MOD_W'(2 * CENTURY))
               && (ymod_reg != MOD_W'(3 * CENTURY));
    assign len  = month_length(month_reg, leap);

    assign day_sum   = (AMOUNT_BITS + 1)'(day_reg) + (AMOUNT_BITS + 1)'(amt_reg);
    assign fits      = (day_sum <= (AMOUNT_BITS + 1)'(len));
    assign at_end    = (month_reg == MONTH_W'(MONTHS_PER_YEAR)) && (year_reg == YEAR_MAX);
    assign step_days = len - day_reg + DAY_W'(1);
    assign ymod_inc  = (ymod_reg == MOD_W'(YEAR_CYCLE - 1)) ? '0 : ymod_reg + MOD_W'(1);

    assign year_hi   = MUL_W'(year_reg >> CYCLE_SHIFT);
    assign mul_a     = cmd.mod_mul ? year_hi : MUL_W'(div_reg >> MONTH_SHIFT);
    assign mul_b     = cmd.mod_mul ? RECIP_CYCLE : RECIP_MONTHS;
    assign mul_p     = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign month_rem = div_reg - DIV_W'(quo_reg) * DIV_W'(MONTHS_PER_YEAR);
    assign cyc_rem   = year_hi - MUL_W'(quo_reg) * MUL_W'(CYCLE_ODD);

    assign year_sum_month = SUM_W'(year_reg) + SUM_W'(quo_reg);
    assign year_sum_year  = SUM_W'(year_reg) + SUM_W'(amt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            year_reg  <= YEAR_BITS'(RESET_YEAR);
            month_reg <= MONTH_W'(RESET_MONTH);
            day_reg   <= DAY_W'(RESET_DAY);
            ymod_reg  <= MOD_W'(RESET_YEAR % YEAR_CYCLE);
            ovf_reg   <= 1'b0;
        end else begin
            if (cmd.latch) begin
                ovf_reg <= 1'b0;
            end
            if (cmd.set_apply) begin
                if (yv_wide > 32'(YEAR_MAX)) begin
                    year_reg <= YEAR_MAX;
                    ovf_reg  <= 1'b1;
                end else begin
                    year_reg <= yv_wide[YEAR_BITS-1:0];
                end
                if (mv_reg < MONTH_W'(1)) begin
                    month_reg <= MONTH_W'(1);
                end else if (mv_reg > MONTH_W'(MONTHS_PER_YEAR)) begin
                    month_reg <= MONTH_W'(MONTHS_PER_YEAR);
                end else begin
                    month_reg <= mv_reg;
                end
                day_reg <= dv_reg;
            end
            if (cmd.day_step) begin
                if (fits) begin
                    day_reg <= day_sum[DAY_W-1:0];
                end else if (at_end) begin
                    year_reg  <= YEAR_MAX;
                    month_reg <= MONTH_W'(MONTHS_PER_YEAR);
                    day_reg   <= DAY_W'(LAST_DAY);
                    ovf_reg   <= 1'b1;
                end else begin
                    day_reg <= DAY_W'(1);
                    if (month_reg >= MONTH_W'(MONTHS_PER_YEAR)) begin
                        year_reg  <= year_reg + YEAR_BITS'(1);
                        month_reg <= MONTH_W'(1);
                        ymod_reg  <= ymod_inc;
                    end else begin
                        month_reg <= month_reg + MONTH_W'(1);
                    end
                end
            end
            if (cmd.month_apply) begin
                if (year_sum_month > SUM_W'(YEAR_MAX)) begin
                    year_reg  <= YEAR_MAX;
                    month_reg <= MONTH_W'(MONTHS_PER_YEAR);
                    day_reg   <= DAY_W'(LAST_DAY);
                    ovf_reg   <= 1'b1;
                end else begin
                    year_reg  <= year_sum_month[YEAR_BITS-1:0];
                    month_reg <= month_rem[MONTH_W-1:0] + MONTH_W'(1);
                end
            end
            if (cmd.year_apply) begin
                if (year_sum_year > SUM_W'(YEAR_MAX)) begin
                    year_reg  <= YEAR_MAX;
                    month_reg <= MONTH_W'(MONTHS_PER_YEAR);
                    day_reg   <= DAY_W'(LAST_DAY);
                    ovf_reg   <= 1'b1;
                end else begin
                    year_reg <= year_sum_year[YEAR_BITS-1:0];
                end
            end
            if (cmd.mod_apply) begin
                ymod_reg <= {cyc_rem[MOD_W-CYCLE_SHIFT-1:0], year_reg[CYCLE_SHIFT-1:0]};
            end
            if (cmd.clamp) begin
                if (day_reg < DAY_W'(1)) begin
                    day_reg <= DAY_W'(1);
                end else if (day_reg > len) begin
                    day_reg <= len;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch) begin
            op_reg  <= op_t'(operation);
            yv_reg  <= year_value;
            mv_reg  <= month_value;
            dv_reg  <= day_value;
            amt_reg <= amount_wide[AMOUNT_BITS-1:0];
        end else if (cmd.day_step && !fits && !at_end) begin
            amt_reg <= amt_reg - AMOUNT_BITS'(step_days);
        end
        if (cmd.div_load) begin
            div_reg <= DIV_W'(month_reg - MONTH_W'(1)) + DIV_W'(amt_reg);
        end
        if (cmd.div_mul || cmd.mod_mul) begin
            quo_reg <= mul_p[PROD_W-1:RECIP_SHIFT];
        end
    end

    assign status.op       = op_reg;
    assign status.day_fin  = fits || at_end;

    assign year_out      = year_wide[YEAR_W-1:0];
    assign month_out     = month_reg;
    assign day_out       = day_reg;
    assign year_overflow = ovf_reg;

endmodule

// ===== rtl/calendar_date_adder_unit.sv =====
// Channel  | Handshake        | Fields
// ---------+------------------+-----------------------------------------------------
// item in  | start, busy      | operation, year_value, month_value, day_value, amount
// item out | done (one cycle) | year_out, month_out, day_out, year_overflow
//
// An item is taken when start is high and busy is low; busy drops in the cycle after
// done. Each item passes through dispatch, its own states, then the year-modulo and
// clamp states: set for a set item, year for add-years, divide load, divide and month
// for add-months, and day steps, one per month crossed, until the days fit for add-days.
// The year remainder by 400 and the month quotient by 12 each come from a registered
// reciprocal multiply; a following state forms the remainder and applies the result.
// Reset loads year 2012, month 7 and day 12. The receiver cannot stall done.
module calendar_date_adder_unit
    import cda_pkg::*;
#(
    parameter int YEAR_BITS   = YEAR_BITS_DEF,
    parameter int AMOUNT_BITS = AMOUNT_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          operation,
    input  logic [YEAR_W-1:0]   year_value,
    input  logic [MONTH_W-1:0]  month_value,
    input  logic [DAY_W-1:0]    day_value,
    input  logic [AMOUNT_W-1:0] amount,
    output logic                done,
    output logic [YEAR_W-1:0]   year_out,
    output logic [MONTH_W-1:0]  month_out,
    output logic [DAY_W-1:0]    day_out,
    output logic                year_overflow
);

    cda_cmd_t    cmd;
    cda_status_t status;

    cda_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    cda_datapath #(
        .YEAR_BITS   (YEAR_BITS),
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .operation     (operation),
        .year_value    (year_value),
        .month_value   (month_value),
        .day_value     (day_value),
        .amount        (amount),
        .year_out      (year_out),
        .month_out     (month_out),
        .day_out       (day_out),
        .year_overflow (year_overflow)
    );

endmodule
